// ----- rtl/pdt_pkg.sv -----
`default_nettype none

package pdt_pkg;

  // Field widths
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned RSSI_W   = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned CDATA_W  = 16;

  // Number of valid target slots; reports for slots at or above this count as reports that saw nothing
  localparam int unsigned TARGET_SLOTS = 8;
  localparam logic [SLOT_W+1:0] SLOT_LIMIT = (SLOT_W+2)'(TARGET_SLOTS);

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Register reset values
  localparam logic signed [RSSI_W-1:0] THRESHOLD_RST = -8'sd75;
  localparam logic [AGE_W-1:0] PULSE_RST    = 16'd700;
  localparam logic [AGE_W-1:0] DEBOUNCE_RST = 16'd1500;
  localparam logic [AGE_W-1:0] LOST_RST     = 16'd30000;
  localparam logic [AGE_W-1:0] RETRY_RST    = 16'd5000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SCAN   = 2'd1,
    OP_BUTTON = 2'd2,
    OP_LINK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    LINK_DOWN   = 2'd0,
    LINK_UP     = 2'd1,
    LINK_FAILED = 2'd2
  } link_status_t;

  typedef enum logic [1:0] {
    OPEN_NONE      = 2'd0,
    OPEN_PROXIMITY = 2'd1,
    OPEN_BUTTON    = 2'd2
  } open_event_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_PULSE     = 3'd1,
    CFG_DEBOUNCE  = 3'd2,
    CFG_LOST      = 3'd3,
    CFG_RETRY     = 3'd4
  } cfg_index_t;

  // One result word
  typedef struct packed {
    logic                     relay_drive;
    logic                     led_drive;
    logic                     connect_request;
    logic                     target_valid;
    logic [SLOT_W-1:0]        target_slot;
    logic signed [RSSI_W-1:0] smoothed_dbm;
    logic                     found_event;
    logic [1:0]               open_event;
    logic                     ignored_event;
    logic                     lost_event;
  } result_t;

  // Millisecond age counter step, saturating at full scale
  function automatic logic [AGE_W-1:0] sat_add(input logic [AGE_W-1:0] a,
                                               input logic [AGE_W-1:0] b);
    logic [AGE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
  endfunction

  // Mean of the valid history entries, truncated toward zero
  function automatic logic signed [RSSI_W-1:0] hist_avg(
      input logic signed [RSSI_W-1:0] h0,
      input logic signed [RSSI_W-1:0] h1,
      input logic [1:0]               v);
    logic signed [RSSI_W:0] sum;
    logic signed [RSSI_W:0] adj;
    logic signed [RSSI_W-1:0] res;
    sum = {h0[RSSI_W-1], h0} + {h1[RSSI_W-1], h1};
    // add one to negative sums so the shift rounds toward zero
    adj = sum + {{RSSI_W{1'b0}}, sum[RSSI_W]};
    case (v)
      2'b00:   res = '0;
      2'b01:   res = h0;
      2'b10:   res = h1;
      2'b11:   res = adj[RSSI_W:1];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pdt_in_if.sv -----
`default_nettype none

interface pdt_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [pdt_pkg::AGE_W-1:0]        elapsed_ms;
  logic                             seen;
  logic signed [pdt_pkg::RSSI_W-1:0] best_rssi;
  logic [pdt_pkg::SLOT_W-1:0]       best_slot;
  logic [1:0]                       link_status;

  modport source (output valid, opcode, elapsed_ms, seen, best_rssi, best_slot,
                  link_status, input ready);
  modport sink (input valid, opcode, elapsed_ms, seen, best_rssi, best_slot,
                link_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/pdt_out_if.sv -----
`default_nettype none

interface pdt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              relay_drive;
  logic                              led_drive;
  logic                              connect_request;
  logic                              target_valid;
  logic [pdt_pkg::SLOT_W-1:0]        target_slot;
  logic signed [pdt_pkg::RSSI_W-1:0] smoothed_dbm;
  logic                              found_event;
  logic [1:0]                        open_event;
  logic                              ignored_event;
  logic                              lost_event;

  modport source (output valid, relay_drive, led_drive, connect_request, target_valid,
                  target_slot, smoothed_dbm, found_event, open_event, ignored_event,
                  lost_event, input ready);
  modport sink (input valid, relay_drive, led_drive, connect_request, target_valid,
                target_slot, smoothed_dbm, found_event, open_event, ignored_event,
                lost_event, output ready);
endinterface

`default_nettype wire

// ----- rtl/pdt_cfg_if.sv -----
`default_nettype none

interface pdt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pdt_pkg::CIDX_W-1:0]  index;
  logic [pdt_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/proximity_door_trigger.sv -----
`default_nettype none

// Proximity door trigger. Every word on the input channel (tick, scan report,
// button press or link event) yields exactly one result word. A word is taken
// into an input register, evaluated combinationally against the block state,
// and the result lands in an output register. One word can be accepted every
// cycle while results are taken. When the output stalls, the input register
// holds one more word and then in_ch.ready drops until the waiting result
// leaves. Configuration writes are taken every cycle (cfg_ch.ready is always
// high) and must only be issued while no word is in flight; indexes beyond the
// register list are ignored. Scan reports for slots at or above TARGET_SLOTS
// count as reports that saw nothing.
module proximity_door_trigger (
  input  wire               clk,
  input  wire               rst_n,
  pdt_in_if.sink            in_ch,
  pdt_out_if.source         out_ch,
  pdt_cfg_if.sink           cfg_ch
);

  localparam int unsigned AW = pdt_pkg::AGE_W;
  localparam int unsigned RW = pdt_pkg::RSSI_W;
  localparam int unsigned SW = pdt_pkg::SLOT_W;

  // Configuration registers
  logic signed [RW-1:0] thr_r;
  logic [AW-1:0]        pulse_r, debounce_r, lost_r, retry_gap_r;

  // Input register
  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [AW-1:0]        s1_elapsed_r;
  logic                 s1_seen_r;
  logic signed [RW-1:0] s1_rssi_r;
  logic [SW-1:0]        s1_slot_r;
  logic [1:0]           s1_link_r;

  // Block state
  logic signed [RW-1:0] hist_r [2];
  logic [1:0]           hvalid_r;
  logic                 hptr_r;
  logic                 visible_r, auto_r, gave_r, jdrop_r, link_r, relay_r;
  logic [AW-1:0]        relay_age_r, unseen_age_r, button_age_r, retry_age_r;
  logic                 act_valid_r;
  logic [SW-1:0]        act_slot_r;

  // Next state
  logic signed [RW-1:0] h0_nxt, h1_nxt;
  logic [1:0]           hvalid_nxt;
  logic                 hptr_nxt;
  logic                 visible_nxt, auto_nxt, gave_nxt, jdrop_nxt, link_nxt, relay_nxt;
  logic [AW-1:0]        relay_age_nxt, unseen_age_nxt, button_age_nxt, retry_age_nxt;
  logic                 act_valid_nxt;
  logic [SW-1:0]        act_slot_nxt;

  // Output register
  logic                 out_valid_r;
  pdt_pkg::result_t     res_r, res_nxt;

  logic                 out_free, s1_adv;
  logic                 seen_eff, have_sm;
  logic signed [RW-1:0] sm_scan;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= pdt_pkg::THRESHOLD_RST;
      pulse_r     <= pdt_pkg::PULSE_RST;
      debounce_r  <= pdt_pkg::DEBOUNCE_RST;
      lost_r      <= pdt_pkg::LOST_RST;
      retry_gap_r <= pdt_pkg::RETRY_RST;
    end else if (cfg_ch.valid) begin
      case (pdt_pkg::cfg_index_t'(cfg_ch.index))
        pdt_pkg::CFG_THRESHOLD: thr_r       <= cfg_ch.data[RW-1:0];
        pdt_pkg::CFG_PULSE:     pulse_r     <= cfg_ch.data;
        pdt_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_ch.data;
        pdt_pkg::CFG_LOST:      lost_r      <= cfg_ch.data;
        pdt_pkg::CFG_RETRY:     retry_gap_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r      <= in_ch.opcode;
      s1_elapsed_r <= in_ch.elapsed_ms;
      s1_seen_r    <= in_ch.seen;
      s1_rssi_r    <= in_ch.best_rssi;
      s1_slot_r    <= in_ch.best_slot;
      s1_link_r    <= in_ch.link_status;
    end
  end

  // One item's effect on the state and its result
  always_comb begin
    h0_nxt         = hist_r[0];
    h1_nxt         = hist_r[1];
    hvalid_nxt     = hvalid_r;
    hptr_nxt       = hptr_r;
    visible_nxt    = visible_r;
    auto_nxt       = auto_r;
    gave_nxt       = gave_r;
    jdrop_nxt      = jdrop_r;
    link_nxt       = link_r;
    relay_nxt      = relay_r;
    relay_age_nxt  = relay_age_r;
    unseen_age_nxt = unseen_age_r;
    button_age_nxt = button_age_r;
    retry_age_nxt  = retry_age_r;
    act_valid_nxt  = act_valid_r;
    act_slot_nxt   = act_slot_r;
    res_nxt        = '0;
    have_sm        = 1'b0;
    sm_scan        = '0;
    seen_eff       = s1_seen_r && ({2'b00, s1_slot_r} < pdt_pkg::SLOT_LIMIT);

    case (pdt_pkg::opcode_t'(s1_op_r))
      pdt_pkg::OP_TICK: begin
        relay_age_nxt  = pdt_pkg::sat_add(relay_age_r, s1_elapsed_r);
        unseen_age_nxt = link_r ? '0 : pdt_pkg::sat_add(unseen_age_r, s1_elapsed_r);
        button_age_nxt = pdt_pkg::sat_add(button_age_r, s1_elapsed_r);
        retry_age_nxt  = pdt_pkg::sat_add(retry_age_r, s1_elapsed_r);
        // lost check
        if (visible_r && !link_r && unseen_age_nxt > lost_r) begin
          visible_nxt   = 1'b0;
          auto_nxt      = 1'b0;
          gave_nxt      = 1'b0;
          act_valid_nxt = 1'b0;
          act_slot_nxt  = '0;
          h0_nxt        = '0;
          h1_nxt        = '0;
          hvalid_nxt    = '0;
          hptr_nxt      = 1'b0;
          res_nxt.lost_event = 1'b1;
        end
        // connect attempt
        if (visible_nxt && !link_r && auto_nxt && !gave_nxt &&
            retry_age_nxt > retry_gap_r) begin
          retry_age_nxt           = '0;
          res_nxt.connect_request = act_valid_nxt;
        end
        // end of relay pulse
        if (relay_r && relay_age_nxt > pulse_r) begin
          relay_nxt = 1'b0;
        end
      end
      pdt_pkg::OP_SCAN: begin
        if (!seen_eff) begin
          if (jdrop_r) begin
            jdrop_nxt  = 1'b0;
            auto_nxt   = 1'b0;
            gave_nxt   = 1'b0;
            h0_nxt     = '0;
            h1_nxt     = '0;
            hvalid_nxt = '0;
            hptr_nxt   = 1'b0;
          end
        end else begin
          if (!auto_r) begin
            act_valid_nxt = 1'b1;
            act_slot_nxt  = s1_slot_r;
          end
          unseen_age_nxt = '0;
          if (hptr_r) begin
            h1_nxt = s1_rssi_r;
          end else begin
            h0_nxt = s1_rssi_r;
          end
          hvalid_nxt[hptr_r] = 1'b1;
          hptr_nxt           = !hptr_r;
          sm_scan            = pdt_pkg::hist_avg(h0_nxt, h1_nxt, hvalid_nxt);
          have_sm            = 1'b1;
          if (jdrop_r) begin
            jdrop_nxt = 1'b0;
            if (sm_scan < thr_r) begin
              auto_nxt   = 1'b0;
              gave_nxt   = 1'b0;
              h0_nxt     = '0;
              h1_nxt     = '0;
              hvalid_nxt = '0;
              hptr_nxt   = 1'b0;
            end
          end
          if (!visible_r) begin
            visible_nxt         = 1'b1;
            auto_nxt            = 1'b0;
            gave_nxt            = 1'b0;
            res_nxt.found_event = 1'b1;
          end
          if (!auto_nxt && sm_scan >= thr_r) begin
            auto_nxt           = 1'b1;
            relay_nxt          = 1'b1;
            relay_age_nxt      = '0;
            res_nxt.open_event = pdt_pkg::OPEN_PROXIMITY;
          end
        end
      end
      pdt_pkg::OP_BUTTON: begin
        if (button_age_r > debounce_r) begin
          button_age_nxt     = '0;
          relay_nxt          = 1'b1;
          relay_age_nxt      = '0;
          res_nxt.open_event = pdt_pkg::OPEN_BUTTON;
        end else begin
          res_nxt.ignored_event = 1'b1;
        end
      end
      pdt_pkg::OP_LINK: begin
        case (pdt_pkg::link_status_t'(s1_link_r))
          pdt_pkg::LINK_DOWN: begin
            link_nxt  = 1'b0;
            jdrop_nxt = 1'b1;
          end
          pdt_pkg::LINK_UP:     link_nxt = 1'b1;
          pdt_pkg::LINK_FAILED: gave_nxt = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase

    res_nxt.relay_drive  = relay_nxt;
    res_nxt.led_drive    = visible_nxt;
    res_nxt.target_valid = act_valid_nxt;
    res_nxt.target_slot  = act_valid_nxt ? act_slot_nxt : '0;
    res_nxt.smoothed_dbm = have_sm ? sm_scan
                                   : pdt_pkg::hist_avg(h0_nxt, h1_nxt, hvalid_nxt);
  end

  // State update, one item per advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0]    <= '0;
      hist_r[1]    <= '0;
      hvalid_r     <= '0;
      hptr_r       <= 1'b0;
      visible_r    <= 1'b0;
      auto_r       <= 1'b0;
      gave_r       <= 1'b0;
      jdrop_r      <= 1'b0;
      link_r       <= 1'b0;
      relay_r      <= 1'b0;
      relay_age_r  <= '0;
      unseen_age_r <= '0;
      button_age_r <= pdt_pkg::AGE_MAX;
      retry_age_r  <= pdt_pkg::AGE_MAX;
      act_valid_r  <= 1'b0;
      act_slot_r   <= '0;
    end else if (s1_adv) begin
      hist_r[0]    <= h0_nxt;
      hist_r[1]    <= h1_nxt;
      hvalid_r     <= hvalid_nxt;
      hptr_r       <= hptr_nxt;
      visible_r    <= visible_nxt;
      auto_r       <= auto_nxt;
      gave_r       <= gave_nxt;
      jdrop_r      <= jdrop_nxt;
      link_r       <= link_nxt;
      relay_r      <= relay_nxt;
      relay_age_r  <= relay_age_nxt;
      unseen_age_r <= unseen_age_nxt;
      button_age_r <= button_age_nxt;
      retry_age_r  <= retry_age_nxt;
      act_valid_r  <= act_valid_nxt;
      act_slot_r   <= act_slot_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.relay_drive     = res_r.relay_drive;
  assign out_ch.led_drive       = res_r.led_drive;
  assign out_ch.connect_request = res_r.connect_request;
  assign out_ch.target_valid    = res_r.target_valid;
  assign out_ch.target_slot     = res_r.target_slot;
  assign out_ch.smoothed_dbm    = res_r.smoothed_dbm;
  assign out_ch.found_event     = res_r.found_event;
  assign out_ch.open_event      = res_r.open_event;
  assign out_ch.ignored_event   = res_r.ignored_event;
  assign out_ch.lost_event      = res_r.lost_event;

  // Checks
  a_open_drives_relay: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_nxt.open_event != pdt_pkg::OPEN_NONE |=> out_ch.relay_drive)
    else $error("door opened without relay drive");

  a_lost_clears_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.lost_event |-> !out_ch.led_drive && !out_ch.target_valid)
    else $error("lost result still shows presence");

  a_found_sets_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.found_event |-> out_ch.led_drive && out_ch.target_valid)
    else $error("found result without presence");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  a_request_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.connect_request |-> out_ch.target_valid && !out_ch.lost_event)
    else $error("connect request without an active target");

endmodule

`default_nettype wire

// ----- verif/tb_proximity_door_trigger.sv -----
`timescale 1ns / 100ps

module tb_proximity_door_trigger;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_PHASE = 210;
  localparam int MAX_PRINTED = 40;
  // link status code that the block must ignore
  localparam logic [1:0] LINK_UNUSED = 2'd3;

  typedef struct {
    pdt_pkg::opcode_t                  op;
    logic [pdt_pkg::AGE_W-1:0]         elapsed;
    logic                              seen;
    logic signed [pdt_pkg::RSSI_W-1:0] rssi;
    logic [pdt_pkg::SLOT_W-1:0]        slot;
    logic [1:0]                        status;
  } door_word_t;

  logic clk = 1'b0;
  logic rst_n;

  pdt_in_if  in_ch ();
  pdt_out_if out_ch ();
  pdt_cfg_if cfg_ch ();

  proximity_door_trigger i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // predicted door state
  logic signed [pdt_pkg::RSSI_W-1:0] hist [2];
  logic [1:0]               hist_vld;
  logic                     hist_ptr;
  logic                     visible, auto_opened, gave_up, just_dropped, link_up, relay_on;
  logic [pdt_pkg::AGE_W-1:0] relay_age, unseen_age, button_age, retry_age;
  logic                     tgt_vld;
  logic [pdt_pkg::SLOT_W-1:0] tgt_slot;

  // register copies
  logic signed [pdt_pkg::RSSI_W-1:0] thr_dbm;
  logic [pdt_pkg::AGE_W-1:0] pulse_ms, debounce_lim, lost_lim, retry_lim;

  pdt_pkg::result_t door_results [$];
  pdt_pkg::result_t want;

  int n_errors = 0;
  int n_checked = 0;
  int n_cycles = 0;
  int burst_left = 0;
  int n_settings = 0;
  int n_ticks = 0, n_scans = 0, n_buttons = 0, n_links = 0;
  int n_found = 0, n_prox = 0, n_btn_open = 0, n_ignored = 0, n_lost = 0, n_req = 0;
  logic [9:0] rx_phase = '0;

  // mismatch report: one line, counted
  task automatic flag_error(string msg);
    if (n_errors < MAX_PRINTED) $display("tb: ERROR at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic [pdt_pkg::AGE_W-1:0] age_step(logic [pdt_pkg::AGE_W-1:0] a,
                                                         logic [pdt_pkg::AGE_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > int'(pdt_pkg::AGE_MAX)) ? pdt_pkg::AGE_MAX : s[pdt_pkg::AGE_W-1:0];
  endfunction

  function automatic int mean_rssi();
    int sum;
    int n;
    sum = 0;
    n = 0;
    for (int i = 0; i < 2; i++) begin
      if (hist_vld[i]) begin
        sum += int'(hist[i]);
        n++;
      end
    end
    // integer division truncates toward zero
    return (n > 0) ? sum / n : 0;
  endfunction

  function automatic void wipe_history();
    hist[0] = '0;
    hist[1] = '0;
    hist_vld = '0;
    hist_ptr = 1'b0;
  endfunction

  function automatic void door_reset();
    thr_dbm = pdt_pkg::THRESHOLD_RST;
    pulse_ms = pdt_pkg::PULSE_RST;
    debounce_lim = pdt_pkg::DEBOUNCE_RST;
    lost_lim = pdt_pkg::LOST_RST;
    retry_lim = pdt_pkg::RETRY_RST;
    wipe_history();
    visible = 1'b0;
    auto_opened = 1'b0;
    gave_up = 1'b0;
    just_dropped = 1'b0;
    link_up = 1'b0;
    relay_on = 1'b0;
    relay_age = '0;
    unseen_age = '0;
    button_age = pdt_pkg::AGE_MAX;
    retry_age = pdt_pkg::AGE_MAX;
    tgt_vld = 1'b0;
    tgt_slot = '0;
  endfunction

  // advance the door state by one word and return the expected result word
  function automatic pdt_pkg::result_t door_step(door_word_t w);
    pdt_pkg::result_t     r;
    logic                 req, found, ignored, lost, have_avg, seen_ok;
    pdt_pkg::open_event_t oe;
    int                   avg;
    req = 1'b0;
    found = 1'b0;
    ignored = 1'b0;
    lost = 1'b0;
    have_avg = 1'b0;
    oe = pdt_pkg::OPEN_NONE;
    avg = 0;
    case (w.op)
      pdt_pkg::OP_TICK: begin
        n_ticks++;
        relay_age = age_step(relay_age, w.elapsed);
        unseen_age = age_step(unseen_age, w.elapsed);
        button_age = age_step(button_age, w.elapsed);
        retry_age = age_step(retry_age, w.elapsed);
        if (link_up) unseen_age = '0;
        // lost check
        if (visible && !link_up && unseen_age > lost_lim) begin
          visible = 1'b0;
          auto_opened = 1'b0;
          gave_up = 1'b0;
          tgt_vld = 1'b0;
          tgt_slot = '0;
          wipe_history();
          lost = 1'b1;
        end
        // connect attempt
        if (visible && !link_up && auto_opened && !gave_up && retry_age > retry_lim) begin
          retry_age = '0;
          req = tgt_vld;
        end
        // relay pulse end
        if (relay_on && relay_age > pulse_ms) relay_on = 1'b0;
      end
      pdt_pkg::OP_SCAN: begin
        n_scans++;
        seen_ok = w.seen && (int'(w.slot) < pdt_pkg::TARGET_SLOTS);
        if (!seen_ok) begin
          if (just_dropped) begin
            just_dropped = 1'b0;
            auto_opened = 1'b0;
            gave_up = 1'b0;
            wipe_history();
          end
        end else begin
          if (!auto_opened) begin
            tgt_vld = 1'b1;
            tgt_slot = w.slot;
          end
          unseen_age = '0;
          hist[hist_ptr] = w.rssi;
          hist_vld[hist_ptr] = 1'b1;
          hist_ptr = ~hist_ptr;
          avg = mean_rssi();
          have_avg = 1'b1;
          if (just_dropped) begin
            just_dropped = 1'b0;
            if (avg < int'(thr_dbm)) begin
              auto_opened = 1'b0;
              gave_up = 1'b0;
              wipe_history();
            end
          end
          if (!visible) begin
            visible = 1'b1;
            auto_opened = 1'b0;
            gave_up = 1'b0;
            found = 1'b1;
          end
          if (!auto_opened && avg >= int'(thr_dbm)) begin
            auto_opened = 1'b1;
            relay_on = 1'b1;
            relay_age = '0;
            oe = pdt_pkg::OPEN_PROXIMITY;
          end
        end
      end
      pdt_pkg::OP_BUTTON: begin
        n_buttons++;
        if (button_age > debounce_lim) begin
          button_age = '0;
          relay_on = 1'b1;
          relay_age = '0;
          oe = pdt_pkg::OPEN_BUTTON;
        end else begin
          ignored = 1'b1;
        end
      end
      default: begin
        n_links++;
        case (w.status)
          pdt_pkg::LINK_DOWN: begin
            link_up = 1'b0;
            just_dropped = 1'b1;
          end
          pdt_pkg::LINK_UP:     link_up = 1'b1;
          pdt_pkg::LINK_FAILED: gave_up = 1'b1;
          default: ;
        endcase
      end
    endcase
    if (!have_avg) avg = mean_rssi();

    n_found += found;
    n_prox += (oe == pdt_pkg::OPEN_PROXIMITY);
    n_btn_open += (oe == pdt_pkg::OPEN_BUTTON);
    n_ignored += ignored;
    n_lost += lost;
    n_req += req;

    r.relay_drive = relay_on;
    r.led_drive = visible;
    r.connect_request = req;
    r.target_valid = tgt_vld;
    r.target_slot = tgt_vld ? tgt_slot : '0;
    r.smoothed_dbm = avg[pdt_pkg::RSSI_W-1:0];
    r.found_event = found;
    r.open_event = oe;
    r.ignored_event = ignored;
    r.lost_event = lost;
    return r;
  endfunction

  function automatic door_word_t mk(pdt_pkg::opcode_t op, logic [pdt_pkg::AGE_W-1:0] el,
                                    logic s, logic signed [pdt_pkg::RSSI_W-1:0] rs,
                                    logic [pdt_pkg::SLOT_W-1:0] sl, logic [1:0] st);
    door_word_t w;
    w.op = op;
    w.elapsed = el;
    w.seen = s;
    w.rssi = rs;
    w.slot = sl;
    w.status = st;
    return w;
  endfunction

  // RSSI in -128..0, half of the time close to the open threshold
  function automatic logic signed [pdt_pkg::RSSI_W-1:0] rand_rssi();
    int v;
    if ($urandom_range(0, 1) != 0) v = int'(thr_dbm) + int'($urandom_range(0, 20)) - 10;
    else v = -int'($urandom_range(0, 128));
    if (v > 0) v = 0;
    if (v < -128) v = -128;
    return v[pdt_pkg::RSSI_W-1:0];
  endfunction

  // tick length: mostly short, some long, a few at the extremes
  function automatic logic [pdt_pkg::AGE_W-1:0] rand_elapsed(bit present);
    int v;
    int scale;
    v = $urandom_range(0, 99);
    scale = present ? 1 : 3;
    if (v < 45) return 16'($urandom_range(0, 300 * scale));
    if (v < 80) return 16'($urandom_range(0, 3000 * scale));
    if (v < 95) return 16'($urandom_range(0, 20000 * scale));
    if (v < 97) return '0;
    if (v < 99) return pdt_pkg::AGE_MAX;
    return 16'($urandom);
  endfunction

  // one word of a presence or absence episode; some words are plain noise
  function automatic door_word_t rand_word(bit present);
    door_word_t w;
    int pick;
    int v;
    w = mk(pdt_pkg::opcode_t'($urandom_range(0, 3)), 16'($urandom),
           1'($urandom_range(0, 1)), rand_rssi(),
           3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 8) return w;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.op = pdt_pkg::OP_SCAN;
      w.seen = present ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
    end else if (pick < 75) begin
      w.op = pdt_pkg::OP_TICK;
      w.elapsed = rand_elapsed(present);
    end else if (pick < 85) begin
      w.op = pdt_pkg::OP_BUTTON;
    end else begin
      w.op = pdt_pkg::OP_LINK;
      v = $urandom_range(0, 99);
      if (v < 35) w.status = pdt_pkg::LINK_DOWN;
      else if (v < (present ? 75 : 45)) w.status = pdt_pkg::LINK_UP;
      else if (v < 97) w.status = pdt_pkg::LINK_FAILED;
      else w.status = LINK_UNUSED;
    end
    return w;
  endfunction

  // send one word in bursts with random gaps; predict on acceptance
  task automatic send_word(door_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 15);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= w.op;
    in_ch.elapsed_ms <= w.elapsed;
    in_ch.seen <= w.seen;
    in_ch.best_rssi <= w.rssi;
    in_ch.best_slot <= w.slot;
    in_ch.link_status <= w.status;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    door_results.push_back(door_step(w));
  endtask

  // hold off the sender until every expected word has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (door_results.size() != 0) @(posedge clk);
  endtask

  // write all five registers; only called with the block idle
  task automatic apply_config(logic signed [pdt_pkg::RSSI_W-1:0] thr,
                              logic [pdt_pkg::AGE_W-1:0] pulse,
                              logic [pdt_pkg::AGE_W-1:0] deb,
                              logic [pdt_pkg::AGE_W-1:0] lost,
                              logic [pdt_pkg::AGE_W-1:0] retry);
    logic [pdt_pkg::CDATA_W-1:0] vals [5];
    pdt_pkg::cfg_index_t         idx [5];
    int                          i;
    vals = '{{{8{thr[pdt_pkg::RSSI_W-1]}}, thr}, pulse, deb, lost, retry};
    idx = '{pdt_pkg::CFG_THRESHOLD, pdt_pkg::CFG_PULSE, pdt_pkg::CFG_DEBOUNCE,
            pdt_pkg::CFG_LOST, pdt_pkg::CFG_RETRY};
    for (i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= vals[i];
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      case (idx[i])
        pdt_pkg::CFG_THRESHOLD: thr_dbm = vals[i][pdt_pkg::RSSI_W-1:0];
        pdt_pkg::CFG_PULSE:     pulse_ms = vals[i];
        pdt_pkg::CFG_DEBOUNCE:  debounce_lim = vals[i];
        pdt_pkg::CFG_LOST:      lost_lim = vals[i];
        default:                retry_lim = vals[i];
      endcase
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // alternating presence and absence episodes, with a full drain now and then
  task automatic run_traffic(int n_words);
    int  done;
    int  len;
    int  k;
    bit  present;
    done = 0;
    present = 1'b0;
    while (done < n_words) begin
      present = ~present;
      len = $urandom_range(4, 40);
      for (k = 0; k < len && done < n_words; k++) begin
        send_word(rand_word(present));
        done++;
        if (done % 100 == 0) wait_drain();
      end
    end
  endtask

  // walk through every opcode and the corner cases at reset settings
  task automatic test_directed_cases();
    send_word(mk(pdt_pkg::OP_TICK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_BUTTON, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_BUTTON, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, pdt_pkg::AGE_MAX, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b0, -8'sd20, 3'd3, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, -8'sd128, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, 8'sd0, 3'd7, pdt_pkg::LINK_DOWN));
    // odd negative sums truncate toward zero
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, -8'sd75, 3'd2, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, -8'sd76, 3'd1, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, 16'd6000, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, 16'd100, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_LINK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_UP));
    send_word(mk(pdt_pkg::OP_TICK, pdt_pkg::AGE_MAX, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_LINK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_FAILED));
    send_word(mk(pdt_pkg::OP_LINK, 16'd0, 1'b0, 8'sd0, 3'd0, LINK_UNUSED));
    send_word(mk(pdt_pkg::OP_BUTTON, 16'd0, 1'b1, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_LINK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    // weak report right after a drop clears the history
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, -8'sd128, 3'd4, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, pdt_pkg::AGE_MAX, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_LINK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, pdt_pkg::AGE_MAX, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_SCAN, 16'd0, 1'b1, 8'sd0, 3'd5, pdt_pkg::LINK_DOWN));
    send_word(mk(pdt_pkg::OP_TICK, 16'd0, 1'b0, 8'sd0, 3'd0, pdt_pkg::LINK_DOWN));
  endtask

  // register extremes: everything opens and loses at once, then nothing times out
  task automatic test_config_extremes();
    wait_drain();
    apply_config(-8'sd128, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(WORDS_PER_PHASE);
    wait_drain();
    apply_config(8'sd0, pdt_pkg::AGE_MAX, pdt_pkg::AGE_MAX, pdt_pkg::AGE_MAX,
                 pdt_pkg::AGE_MAX);
    run_traffic(WORDS_PER_PHASE);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      wait_drain();
      apply_config(8'(-int'($urandom_range(0, 128))), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 5000)), 16'($urandom_range(0, 40000)),
                   16'($urandom_range(0, 10000)));
      run_traffic(WORDS_PER_PHASE);
    end
  endtask

  task automatic test_default_traffic();
    wait_drain();
    apply_config(pdt_pkg::THRESHOLD_RST, pdt_pkg::PULSE_RST, pdt_pkg::DEBOUNCE_RST,
                 pdt_pkg::LOST_RST, pdt_pkg::RETRY_RST);
    run_traffic(WORDS_PER_PHASE);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_v);
    if (got !== exp_v)
      flag_error($sformatf("word %0d %s: got %0h, expected %0h", n_checked, name, got, exp_v));
  endtask

  // compare each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (door_results.size() == 0) begin
        flag_error("result word with no prediction pending");
      end else begin
        want = door_results.pop_front();
        check_field("relay_drive", 8'(out_ch.relay_drive), 8'(want.relay_drive));
        check_field("led_drive", 8'(out_ch.led_drive), 8'(want.led_drive));
        check_field("connect_request", 8'(out_ch.connect_request),
                    8'(want.connect_request));
        check_field("target_valid", 8'(out_ch.target_valid), 8'(want.target_valid));
        check_field("target_slot", 8'(out_ch.target_slot), 8'(want.target_slot));
        check_field("smoothed_dbm", 8'(out_ch.smoothed_dbm), 8'(want.smoothed_dbm));
        check_field("found_event", 8'(out_ch.found_event), 8'(want.found_event));
        check_field("open_event", 8'(out_ch.open_event), 8'(want.open_event));
        check_field("ignored_event", 8'(out_ch.ignored_event), 8'(want.ignored_event));
        check_field("lost_event", 8'(out_ch.lost_event), 8'(want.lost_event));
        n_checked++;
      end
    end
  end

  // receiver: always ready, random, one in four, then long stalls
  always @(posedge clk) begin
    rx_phase <= rx_phase + 10'd1;
    case (rx_phase[9:8])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 2) != 0);
      2'd2:    out_ch.ready <= (rx_phase[1:0] == 2'd0);
      default: out_ch.ready <= (rx_phase[4:0] >= 5'd22);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles, %0d words pending", n_cycles,
               door_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= pdt_pkg::OP_TICK;
    in_ch.elapsed_ms <= '0;
    in_ch.seen <= 1'b0;
    in_ch.best_rssi <= '0;
    in_ch.best_slot <= '0;
    in_ch.link_status <= pdt_pkg::LINK_DOWN;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= pdt_pkg::CFG_THRESHOLD;
    cfg_ch.data <= '0;
    door_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_config_extremes();
    test_random_settings();
    test_default_traffic();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d words checked (%0d ticks, %0d scans, %0d presses, %0d link events),",
             n_checked, n_ticks, n_scans, n_buttons, n_links);
    $display("tb: %0d settings; events: %0d found, %0d proximity, %0d button, %0d ignored,%s",
             n_settings, n_found, n_prox, n_btn_open, n_ignored,
             $sformatf(" %0d lost, %0d requests", n_lost, n_req));
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
